>>> hw/rtl/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg
// shared types, register and code names, and saturating helpers for the
// heating demand sequencer
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int TempW    = 16;
  localparam int MarginW  = 15;
  localparam int TimeW    = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int WideW    = TempW + 2;

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic signed [WideW-1:0] wide_t;
  typedef logic [MarginW-1:0]      margin_t;
  typedef logic [TimeW-1:0]        ms_t;

  localparam wide_t WideMax = WideW'((2 ** (TempW - 1)) - 1);
  localparam wide_t WideMin = -WideW'(2 ** (TempW - 1));

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WEATHER_MODE      = 3'd0,
    REG_OUTSIDE_THRESHOLD = 3'd1,
    REG_ROOM_SETPOINT     = 3'd2,
    REG_OVERHEAT_MARGIN   = 3'd3,
    REG_HYSTERESIS        = 3'd4,
    REG_REFRESH_INTERVAL  = 3'd5,
    REG_CHANGE_THRESHOLD  = 3'd6
  } cfg_reg_t;

  // burner request actions
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // stop reasons
  typedef enum logic [2:0] {
    STOP_NONE       = 3'd0,
    STOP_REMOTE_OFF = 3'd1,
    STOP_BOILER_OFF = 3'd2,
    STOP_HEAT_OFF   = 3'd3,
    STOP_WATER      = 3'd4,
    STOP_REACHED    = 3'd5,
    STOP_SENSOR     = 3'd6
  } reason_t;

  localparam logic CMD_EVALUATE = 1'b0;
  localparam logic CMD_SAFETY   = 1'b1;

  typedef struct packed {
    logic    weather_mode;
    temp_t   outside_threshold;
    temp_t   room_setpoint;
    margin_t overheat_margin;
    margin_t hysteresis;
    ms_t     refresh_interval;
    margin_t change_threshold;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    weather_mode:      1'b0,
    outside_threshold: 16'sd160,
    room_setpoint:     16'sd200,
    overheat_margin:   15'd20,
    hysteresis:        15'd5,
    refresh_interval:  32'd300000,
    change_threshold:  15'd10
  };

  function automatic wide_t wide_s(input temp_t v);
    return WideW'(v);
  endfunction

  function automatic wide_t wide_u(input margin_t v);
    return $signed(WideW'(v));
  endfunction

  // clamp to the 16-bit signed range
  function automatic temp_t sat16(input wide_t v);
    temp_t r;
    if (v > WideMax) begin
      r = WideMax[TempW-1:0];
    end else if (v < WideMin) begin
      r = WideMin[TempW-1:0];
    end else begin
      r = v[TempW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/hds_in_if.sv
// ----------------------------------------------------------------------------
// hds_in_if
// event channel into the heating demand sequencer
// ----------------------------------------------------------------------------
interface hds_in_if import hds_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [1:0] enables;
  logic [1:0] overrides;
  logic [1:0] water_flags;
  logic       tuning_active;
  logic       sensors_ok;
  logic [1:0] sensor_valid;
  temp_t      room_temp;
  temp_t      outside_temp;
  temp_t      computed_target;
  ms_t        now_ms;

  modport source (
    output valid, cmd, enables, overrides, water_flags, tuning_active,
           sensors_ok, sensor_valid, room_temp, outside_temp, computed_target, now_ms,
    input  ready
  );
  modport sink (
    input  valid, cmd, enables, overrides, water_flags, tuning_active,
           sensors_ok, sensor_valid, room_temp, outside_temp, computed_target, now_ms,
    output ready
  );
endinterface

>>> hw/rtl/hds_out_if.sv
// ----------------------------------------------------------------------------
// hds_out_if
// result channel out of the heating demand sequencer
// ----------------------------------------------------------------------------
interface hds_out_if import hds_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       heating_active;
  logic [1:0] request_action;
  temp_t      boiler_target;
  logic [2:0] stop_reason;
  logic       deferred;

  modport source (
    output valid, heating_active, request_action, boiler_target, stop_reason, deferred,
    input  ready
  );
  modport sink (
    input  valid, heating_active, request_action, boiler_target, stop_reason, deferred,
    output ready
  );
endinterface

>>> hw/rtl/hds_cfg_if.sv
// ----------------------------------------------------------------------------
// hds_cfg_if
// configuration write channel of the heating demand sequencer
// ----------------------------------------------------------------------------
interface hds_cfg_if import hds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/heating_demand_sequencer_unit.sv
// ----------------------------------------------------------------------------
// heating_demand_sequencer_unit
// on/off space-heating sequencer with hysteresis and burner request control
// ----------------------------------------------------------------------------
// Every accepted event produces exactly one result transaction. An event is
// captured in an input register; in the following cycle the decision logic
// (a handful of 16-bit saturating adds and compares plus one 32-bit time
// compare) reads it against the held mode, last target and last refresh time,
// and the result lands in the output register, where it waits for out_ch.ready.
// Result valid rises once the event has moved from the input register into
// the output register; the unit accepts one event per clock, back to back,
// and only backs up when both the input and the output register are full and
// the output is not being taken. State updates as an event moves into the
// output register, so the next event always sees the previous one's effect.
// Configuration writes are always taken (cfg_ch.ready is tied high) and must
// only be issued while no event is in flight; indexes above the last register
// are ignored. No memories, so nothing to clear after reset.
module heating_demand_sequencer_unit import hds_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  hds_in_if.sink   in_ch,
  hds_out_if.source out_ch,
  hds_cfg_if.sink  cfg_ch
);

  typedef struct packed {
    logic       cmd;
    logic [1:0] enables;
    logic [1:0] overrides;
    logic [1:0] water_flags;
    logic       tuning_active;
    logic       sensors_ok;
    logic [1:0] sensor_valid;
    temp_t      room_temp;
    temp_t      outside_temp;
    temp_t      computed_target;
    ms_t        now_ms;
  } item_t;

  // configuration
  cfg_t cfg_r, cfg_nxt;

  // input register stage
  logic  s1_valid_r;
  item_t s1_r;
  logic  s1_adv;
  logic  in_take;

  // held sequencer state
  logic  mode_r, mode_nxt;
  temp_t last_target_r, last_target_nxt;
  ms_t   last_refresh_r, last_refresh_nxt;

  // output register
  logic    out_valid_r;
  logic    out_active_r;
  action_t out_action_r;
  temp_t   out_target_r;
  reason_t out_reason_r;
  logic    out_deferred_r;

  // decision results for the item in the input register
  action_t action;
  reason_t reason;
  temp_t   sent;
  logic    deferred;
  logic    wanted;
  logic    water_wins;
  temp_t   delta;
  temp_t   delta_abs;
  logic    target_moved;
  logic    refresh_due;
  ms_t     elapsed;

  // --------------------------------------------------------------------------
  // handshakes: the input register advances whenever the output slot is free
  // or drains this cycle
  // --------------------------------------------------------------------------
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // --------------------------------------------------------------------------
  // configuration register writes
  // --------------------------------------------------------------------------
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_WEATHER_MODE:      cfg_nxt.weather_mode      = cfg_ch.data[0];
        REG_OUTSIDE_THRESHOLD: cfg_nxt.outside_threshold = cfg_ch.data[TempW-1:0];
        REG_ROOM_SETPOINT:     cfg_nxt.room_setpoint     = cfg_ch.data[TempW-1:0];
        REG_OVERHEAT_MARGIN:   cfg_nxt.overheat_margin   = cfg_ch.data[MarginW-1:0];
        REG_HYSTERESIS:        cfg_nxt.hysteresis        = cfg_ch.data[MarginW-1:0];
        REG_REFRESH_INTERVAL:  cfg_nxt.refresh_interval  = cfg_ch.data[TimeW-1:0];
        REG_CHANGE_THRESHOLD:  cfg_nxt.change_threshold  = cfg_ch.data[MarginW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // demand evaluation against the current mode
  // --------------------------------------------------------------------------
  hds_demand u_demand (
    .cfg          (cfg_r),
    .mode_on      (mode_r),
    .autotune     (s1_r.tuning_active),
    .sensor_valid (s1_r.sensor_valid),
    .room_temp    (s1_r.room_temp),
    .outside_temp (s1_r.outside_temp),
    .wanted       (wanted)
  );

  // --------------------------------------------------------------------------
  // refresh checks: saturated target change and wrapping elapsed time
  // --------------------------------------------------------------------------
  always_comb begin
    delta        = sat16(wide_s(s1_r.computed_target) - wide_s(last_target_r));
    delta_abs    = delta[TempW-1] ? sat16(-wide_s(delta)) : delta;
    target_moved = $unsigned(delta_abs) > {1'b0, cfg_r.change_threshold};
    elapsed      = s1_r.now_ms - last_refresh_r;
    refresh_due  = elapsed > cfg_r.refresh_interval;
  end

  // --------------------------------------------------------------------------
  // sequencer decision
  // --------------------------------------------------------------------------
  always_comb begin
    water_wins       = s1_r.water_flags == 2'b11;
    action           = ACT_NONE;
    reason           = STOP_NONE;
    sent             = '0;
    deferred         = 1'b0;
    mode_nxt         = mode_r;
    last_target_nxt  = last_target_r;
    last_refresh_nxt = last_refresh_r;

    if (s1_r.cmd == CMD_SAFETY) begin
      // safety check only ever turns heating off
      if (mode_r && !s1_r.sensors_ok) begin
        action   = ACT_CLEAR;
        reason   = STOP_SENSOR;
        mode_nxt = 1'b0;
      end
    end else if (s1_r.enables != 2'b11) begin
      // boiler or heating disabled
      if (mode_r) begin
        action   = ACT_CLEAR;
        reason   = s1_r.enables[0] ? STOP_HEAT_OFF : STOP_BOILER_OFF;
        mode_nxt = 1'b0;
      end
    end else if (!mode_r) begin
      // activation path, sensors must pass before turning on
      if (wanted || s1_r.overrides[0]) begin
        if (water_wins) begin
          deferred = 1'b1;
        end else if (s1_r.sensors_ok) begin
          action          = ACT_SET;
          sent            = s1_r.computed_target;
          mode_nxt        = 1'b1;
          last_target_nxt = s1_r.computed_target;
        end
      end
    end else begin
      // running: stop checks in priority order, else maybe refresh
      if (s1_r.overrides[1]) begin
        reason = STOP_REMOTE_OFF;
      end else if (water_wins) begin
        reason = STOP_WATER;
      end else if (!wanted) begin
        reason = STOP_REACHED;
      end else if (!s1_r.sensors_ok) begin
        reason = STOP_SENSOR;
      end
      if (reason != STOP_NONE) begin
        action   = ACT_CLEAR;
        mode_nxt = 1'b0;
      end else if (target_moved || refresh_due) begin
        action           = ACT_SET;
        sent             = s1_r.computed_target;
        last_target_nxt  = s1_r.computed_target;
        last_refresh_nxt = s1_r.now_ms;
      end
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r          <= CfgReset;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      mode_r         <= 1'b0;
      last_target_r  <= '0;
      last_refresh_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r    <= 1'b1;
        mode_r         <= mode_nxt;
        last_target_r  <= last_target_nxt;
        last_refresh_r <= last_refresh_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.cmd             <= in_ch.cmd;
      s1_r.enables         <= in_ch.enables;
      s1_r.overrides       <= in_ch.overrides;
      s1_r.water_flags     <= in_ch.water_flags;
      s1_r.tuning_active   <= in_ch.tuning_active;
      s1_r.sensors_ok      <= in_ch.sensors_ok;
      s1_r.sensor_valid    <= in_ch.sensor_valid;
      s1_r.room_temp       <= in_ch.room_temp;
      s1_r.outside_temp    <= in_ch.outside_temp;
      s1_r.computed_target <= in_ch.computed_target;
      s1_r.now_ms          <= in_ch.now_ms;
    end
    if (s1_adv) begin
      out_active_r   <= mode_nxt;
      out_action_r   <= action;
      out_target_r   <= sent;
      out_reason_r   <= reason;
      out_deferred_r <= deferred;
    end
  end

  // --------------------------------------------------------------------------
  // result channel
  // --------------------------------------------------------------------------
  assign out_ch.valid          = out_valid_r;
  assign out_ch.heating_active = out_active_r;
  assign out_ch.request_action = out_action_r;
  assign out_ch.boiler_target  = out_target_r;
  assign out_ch.stop_reason    = out_reason_r;
  assign out_ch.deferred       = out_deferred_r;

endmodule

>>> hw/rtl/hds_demand.sv
// ----------------------------------------------------------------------------
// hds_demand
// heat demand with hysteresis, room setpoint or outside temperature control
// ----------------------------------------------------------------------------
module hds_demand import hds_pkg::*; (
  input  cfg_t       cfg,
  input  logic       mode_on,
  input  logic       autotune,
  input  logic [1:0] sensor_valid,
  input  temp_t      room_temp,
  input  temp_t      outside_temp,
  output logic       wanted
);

  logic  room_ok;
  logic  out_ok;
  logic  sp_pos;
  logic  cold;
  logic  over;
  temp_t limit;
  temp_t limit_low;
  temp_t room_stop;

  always_comb begin
    room_ok   = sensor_valid[0];
    out_ok    = sensor_valid[1];
    sp_pos    = cfg.room_setpoint > 0;
    cold      = outside_temp < cfg.outside_threshold;
    limit     = sat16(wide_s(cfg.room_setpoint) + wide_u(cfg.overheat_margin));
    limit_low = sat16(wide_s(limit) - wide_u(cfg.hysteresis));
    room_stop = mode_on ? sat16(wide_s(cfg.room_setpoint) + wide_u(cfg.hysteresis))
                        : cfg.room_setpoint;
    // overheat veto, tighter band while off
    over = 1'b0;
    if (room_ok && sp_pos) begin
      over = mode_on ? (room_temp > limit) : (room_temp >= limit_low);
    end
    if (autotune) begin
      wanted = 1'b1;
    end else if (cfg.weather_mode) begin
      wanted = out_ok && cold && !over;
    end else begin
      wanted = room_ok && sp_pos && (room_temp < room_stop);
    end
  end

endmodule

>>> hw/rtl/hds_checker.sv
// ----------------------------------------------------------------------------
// hds_checker
// port-level checks on result transactions of the heating demand sequencer
// ----------------------------------------------------------------------------
module hds_checker import hds_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_active,
  input logic [1:0] out_action,
  input logic [2:0] out_reason,
  input logic       out_deferred
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_active))
    else $error("stalled result changed");

  // a set request leaves heating on
  a_set_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_SET |-> out_active && out_reason == STOP_NONE)
    else $error("set request without heating on");

  // a clear carries a reason and leaves heating off; a reason only with a clear
  a_clear_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_action == ACT_CLEAR) == (out_reason != STOP_NONE)
                  && (out_action != ACT_CLEAR || !out_active))
    else $error("clear request and stop reason disagree");

  // deferral means nothing was requested and heating stays off
  a_defer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deferred |-> out_action == ACT_NONE && !out_active)
    else $error("deferred activation with action or heating on");

endmodule

bind heating_demand_sequencer_unit hds_checker u_hds_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_active   (out_ch.heating_active),
  .out_action   (out_ch.request_action),
  .out_reason   (out_ch.stop_reason),
  .out_deferred (out_ch.deferred)
);

>>> tb/tb_heating_demand_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heating_demand_sequencer_unit
// self-checking bench for the heating demand sequencer: a queue-fed driver
// pushes evaluate and safety-check events through the input channel, an
// in-bench predictor tracks mode, last target and refresh time, and a monitor
// compares every result transaction field by field, under random idling on
// both channels and across several register settings
// ----------------------------------------------------------------------------
module tb_heating_demand_sequencer_unit;
  import hds_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int N_PHASES       = 7;
  localparam int RAND_PER_PHASE = 290;
  // two-stage pipe, spare idle cycles before touching registers or ending
  localparam int IDLE_CYCLES    = 4;

  // register index past the last one, the unit must ignore it
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  // flag encodings for the event fields
  localparam logic [1:0] EN_ALL       = 2'b11;
  localparam logic [1:0] EN_BOILER    = 2'b01;
  localparam logic [1:0] EN_HEAT      = 2'b10;
  localparam logic [1:0] EN_NONE      = 2'b00;
  localparam logic [1:0] OVR_NONE     = 2'b00;
  localparam logic [1:0] OVR_ON       = 2'b01;
  localparam logic [1:0] OVR_OFF      = 2'b10;
  localparam logic [1:0] OVR_BOTH     = 2'b11;
  localparam logic [1:0] WATER_IDLE   = 2'b00;
  localparam logic [1:0] WATER_WINS   = 2'b11;
  localparam logic [1:0] VLD_ALL      = 2'b11;
  localparam logic [1:0] VLD_OUTSIDE  = 2'b10;
  localparam logic [1:0] VLD_NONE     = 2'b00;

  typedef struct {
    logic       cmd;
    logic [1:0] enables;
    logic [1:0] overrides;
    logic [1:0] water_flags;
    logic       tuning_active;
    logic       sensors_ok;
    logic [1:0] sensor_valid;
    temp_t      room_temp;
    temp_t      outside_temp;
    temp_t      computed_target;
    ms_t        now_ms;
  } heat_evt_t;

  typedef struct {
    logic    heating_active;
    action_t request_action;
    temp_t   boiler_target;
    reason_t stop_reason;
    logic    deferred;
  } burner_result_t;

  logic clk;
  logic rst_n;

  hds_in_if  in_ch ();
  hds_out_if out_ch ();
  hds_cfg_if cfg_ch ();

  heating_demand_sequencer_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // events waiting for the driver, and results the unit still owes us
  heat_evt_t      pending_events[$];
  burner_result_t owed_results[$];
  heat_evt_t      cur_evt;

  // predictor copy of the registers and of the sequencer state
  cfg_t plant_cfg;
  logic heat_on;
  int   last_sent;
  ms_t  last_refresh;

  // random stimulus walkers
  ms_t clock_ms;
  int  target_walk;

  // handshake bookkeeping
  logic in_done;
  logic calm;
  int   send_gap;
  int   stall_left;

  int cycle_count;
  int fail_count;
  int events_sent;
  int results_seen;
  int sets_seen;
  int clears_seen;
  int defers_seen;
  int cfg_writes;

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // heating demand against the current mode, hysteresis included
  function automatic logic heat_wanted(input heat_evt_t e);
    int   sp;
    int   thr;
    int   room;
    int   outside;
    int   limit;
    logic cold;
    logic over;
    sp      = $signed(plant_cfg.room_setpoint);
    thr     = $signed(plant_cfg.outside_threshold);
    room    = $signed(e.room_temp);
    outside = $signed(e.outside_temp);
    over    = 1'b0;
    // tuning forces demand no matter what the sensors say
    if (e.tuning_active) return 1'b1;
    if (plant_cfg.weather_mode) begin
      if (!e.sensor_valid[1]) return 1'b0;
      cold = outside < thr;
      // overheat veto only with a valid room reading and a positive setpoint
      if (e.sensor_valid[0] && sp > 0) begin
        limit = clamp16(sp + int'(plant_cfg.overheat_margin));
        if (heat_on) over = room > limit;
        else over = room >= clamp16(limit - int'(plant_cfg.hysteresis));
      end
      return cold && !over;
    end
    if (!e.sensor_valid[0] || sp <= 0) return 1'b0;
    if (!heat_on) return room < sp;
    return room < clamp16(sp + int'(plant_cfg.hysteresis));
  endfunction

  // one event in, one result out, state advanced
  function automatic burner_result_t predict_burner(input heat_evt_t e);
    burner_result_t r;
    logic           want;
    logic           water_wins;
    int             d;
    r.heating_active = 1'b0;
    r.request_action = ACT_NONE;
    r.boiler_target  = '0;
    r.stop_reason    = STOP_NONE;
    r.deferred       = 1'b0;
    water_wins = (e.water_flags == WATER_WINS);
    if (e.cmd == CMD_SAFETY) begin
      if (heat_on && !e.sensors_ok) begin
        r.request_action = ACT_CLEAR;
        r.stop_reason    = STOP_SENSOR;
        heat_on          = 1'b0;
      end
    end else if (e.enables != EN_ALL) begin
      if (heat_on) begin
        r.request_action = ACT_CLEAR;
        r.stop_reason    = e.enables[0] ? STOP_HEAT_OFF : STOP_BOILER_OFF;
        heat_on          = 1'b0;
      end
    end else if (!heat_on) begin
      if (heat_wanted(e) || e.overrides[0]) begin
        if (water_wins) begin
          r.deferred = 1'b1;
        end else if (e.sensors_ok) begin
          r.request_action = ACT_SET;
          r.boiler_target  = e.computed_target;
          heat_on          = 1'b1;
          last_sent        = $signed(e.computed_target);
        end
      end
    end else begin
      want = heat_wanted(e);
      if (e.overrides[1]) r.stop_reason = STOP_REMOTE_OFF;
      else if (water_wins) r.stop_reason = STOP_WATER;
      else if (!want) r.stop_reason = STOP_REACHED;
      else if (!e.sensors_ok) r.stop_reason = STOP_SENSOR;
      if (r.stop_reason != STOP_NONE) begin
        r.request_action = ACT_CLEAR;
        heat_on          = 1'b0;
      end else begin
        d = clamp16($signed(e.computed_target) - last_sent);
        if (d < 0) d = clamp16(-d);
        if (d > int'(plant_cfg.change_threshold) ||
            ms_t'(e.now_ms - last_refresh) > plant_cfg.refresh_interval) begin
          r.request_action = ACT_SET;
          r.boiler_target  = e.computed_target;
          last_sent        = $signed(e.computed_target);
          last_refresh     = e.now_ms;
        end
      end
    end
    r.heating_active = heat_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic heat_evt_t heat_event(
    input logic cmd, input logic [1:0] en, input logic [1:0] ovr,
    input logic [1:0] water, input logic at, input logic sok,
    input logic [1:0] vld, input int room, input int outside,
    input int target, input ms_t now);
    heat_evt_t e;
    e.cmd             = cmd;
    e.enables         = en;
    e.overrides       = ovr;
    e.water_flags     = water;
    e.tuning_active   = at;
    e.sensors_ok      = sok;
    e.sensor_valid    = vld;
    e.room_temp       = temp_t'(room);
    e.outside_temp    = temp_t'(outside);
    e.computed_target = temp_t'(target);
    e.now_ms          = now;
    return e;
  endfunction

  function automatic temp_t near_temp(input int center, input int spread);
    return temp_t'(clamp16(center + int'($urandom_range(0, 2 * spread)) - spread));
  endfunction

  // mostly plausible events clustered around the switching points
  function automatic heat_evt_t random_event();
    heat_evt_t e;
    int        sp;
    int        margin;
    int        hys;
    int        ct;
    int        pick;
    ms_t       step_max;
    sp     = $signed(plant_cfg.room_setpoint);
    margin = int'(plant_cfg.overheat_margin);
    hys    = int'(plant_cfg.hysteresis);
    ct     = int'(plant_cfg.change_threshold);
    if ($urandom_range(0, 99) < 8) begin
      // pure noise, every bit free
      e.cmd             = 1'($urandom);
      e.enables         = 2'($urandom);
      e.overrides       = 2'($urandom);
      e.water_flags     = 2'($urandom);
      e.tuning_active   = 1'($urandom);
      e.sensors_ok      = 1'($urandom);
      e.sensor_valid    = 2'($urandom);
      e.room_temp       = temp_t'($urandom);
      e.outside_temp    = temp_t'($urandom);
      e.computed_target = temp_t'($urandom);
      e.now_ms          = ms_t'($urandom);
      return e;
    end
    e.cmd     = ($urandom_range(0, 99) < 12) ? CMD_SAFETY : CMD_EVALUATE;
    e.enables = ($urandom_range(0, 99) < 88) ? EN_ALL : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (pick < 6) e.overrides = OVR_ON;
    else if (pick < 11) e.overrides = OVR_OFF;
    else if (pick < 13) e.overrides = OVR_BOTH;
    else e.overrides = OVR_NONE;
    e.water_flags   = ($urandom_range(0, 99) < 10) ? WATER_WINS
                                                   : 2'($urandom_range(0, 2));
    e.tuning_active = ($urandom_range(0, 99) < 5);
    e.sensors_ok    = ($urandom_range(0, 99) < 90);
    e.sensor_valid  = ($urandom_range(0, 99) < 85) ? VLD_ALL : 2'($urandom);
    if (plant_cfg.weather_mode) e.room_temp = near_temp(sp + margin, hys + margin + 20);
    else e.room_temp = near_temp(sp, hys + 20);
    e.outside_temp = near_temp($signed(plant_cfg.outside_threshold), 30);
    // target wanders around the last one, now and then it jumps
    if ($urandom_range(0, 99) < 10) target_walk = $signed(16'($urandom));
    else target_walk = clamp16(target_walk + int'($urandom_range(0, 4 * ct + 6)) - 2 * ct - 3);
    e.computed_target = temp_t'(target_walk);
    // time advances in steps that straddle the refresh interval
    if ($urandom_range(0, 99) < 5) begin
      clock_ms = ms_t'($urandom);
    end else begin
      step_max = plant_cfg.refresh_interval / 3 + 3;
      clock_ms = clock_ms + ms_t'($urandom_range(0, step_max));
    end
    e.now_ms = clock_ms;
    return e;
  endfunction

  // single register write, predictor copy follows the accepted transaction
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_writes++;
    case (cfg_reg_t'(idx))
      REG_WEATHER_MODE:      plant_cfg.weather_mode      = val[0];
      REG_OUTSIDE_THRESHOLD: plant_cfg.outside_threshold = val[15:0];
      REG_ROOM_SETPOINT:     plant_cfg.room_setpoint     = val[15:0];
      REG_OVERHEAT_MARGIN:   plant_cfg.overheat_margin   = val[14:0];
      REG_HYSTERESIS:        plant_cfg.hysteresis        = val[14:0];
      REG_REFRESH_INTERVAL:  plant_cfg.refresh_interval  = val;
      REG_CHANGE_THRESHOLD:  plant_cfg.change_threshold  = val[14:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input int wm, input int thr, input int sp, input int margin,
                                input int hys, input logic [31:0] refresh, input int change);
    write_reg(REG_WEATHER_MODE, 32'(wm));
    write_reg(REG_OUTSIDE_THRESHOLD, 32'(thr));
    write_reg(REG_ROOM_SETPOINT, 32'(sp));
    write_reg(REG_OVERHEAT_MARGIN, 32'(margin));
    write_reg(REG_HYSTERESIS, 32'(hys));
    write_reg(REG_REFRESH_INTERVAL, refresh);
    write_reg(REG_CHANGE_THRESHOLD, 32'(change));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // sender drained and every owed result back, then let the pipe settle
  task automatic wait_for_idle();
    while (pending_events.size() != 0 || in_ch.valid || owed_results.size() != 0)
      @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: one event held until its transaction, random gaps after it
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : event_driver
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_done || !in_ch.valid) begin
      in_done = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        cur_evt = pending_events.pop_front();
        in_ch.cmd             <= cur_evt.cmd;
        in_ch.enables         <= cur_evt.enables;
        in_ch.overrides       <= cur_evt.overrides;
        in_ch.water_flags     <= cur_evt.water_flags;
        in_ch.tuning_active   <= cur_evt.tuning_active;
        in_ch.sensors_ok      <= cur_evt.sensors_ok;
        in_ch.sensor_valid    <= cur_evt.sensor_valid;
        in_ch.room_temp       <= cur_evt.room_temp;
        in_ch.outside_temp    <= cur_evt.outside_temp;
        in_ch.computed_target <= cur_evt.computed_target;
        in_ch.now_ms          <= cur_evt.now_ms;
        in_ch.valid           <= 1'b1;
        // schedule a gap once this event is taken
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // accepted event: predict its result right away
  always @(posedge clk) begin : event_accept
    if (rst_n && in_ch.valid && in_ch.ready) begin
      owed_results.push_back(predict_burner(cur_evt));
      events_sent++;
      in_done = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall bursts on ready, field-by-field compare
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : result_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 9);
    end
  end

  always @(posedge clk) begin : result_monitor
    burner_result_t want;
    cycle_count++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $error("result transaction with no event outstanding");
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_ch.heating_active !== want.heating_active) begin
          $error("heating_active expected %0d actual %0d",
                 want.heating_active, out_ch.heating_active);
          fail_count++;
        end
        if (out_ch.request_action !== want.request_action) begin
          $error("request_action expected %0d actual %0d",
                 want.request_action, out_ch.request_action);
          fail_count++;
        end
        if (out_ch.boiler_target !== want.boiler_target) begin
          $error("boiler_target expected %0d actual %0d",
                 want.boiler_target, out_ch.boiler_target);
          fail_count++;
        end
        if (out_ch.stop_reason !== want.stop_reason) begin
          $error("stop_reason expected %0d actual %0d",
                 want.stop_reason, out_ch.stop_reason);
          fail_count++;
        end
        if (out_ch.deferred !== want.deferred) begin
          $error("deferred expected %0d actual %0d", want.deferred, out_ch.deferred);
          fail_count++;
        end
        if (want.request_action == ACT_SET) sets_seen++;
        if (want.request_action == ACT_CLEAR) clears_seen++;
        if (want.deferred) defers_seen++;
      end
    end
  end

  // watchdog on the cycle counter
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_heating_demand_sequencer_unit failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence: reset, then one register setting per phase
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.cmd             = CMD_EVALUATE;
    in_ch.enables         = EN_NONE;
    in_ch.overrides       = OVR_NONE;
    in_ch.water_flags     = WATER_IDLE;
    in_ch.tuning_active   = 1'b0;
    in_ch.sensors_ok      = 1'b0;
    in_ch.sensor_valid    = VLD_NONE;
    in_ch.room_temp       = '0;
    in_ch.outside_temp    = '0;
    in_ch.computed_target = '0;
    in_ch.now_ms          = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    plant_cfg    = CfgReset;
    heat_on      = 1'b0;
    last_sent    = 0;
    last_refresh = '0;
    clock_ms     = '0;
    target_walk  = 600;
    in_done      = 1'b0;
    calm         = 1'b0;
    send_gap     = 0;
    stall_left   = 0;
    cycle_count  = 0;
    fail_count   = 0;
    events_sent  = 0;
    results_seen = 0;
    sets_seen    = 0;
    clears_seen  = 0;
    defers_seen  = 0;
    cfg_writes   = 0;

    // synchronous reset, released on a falling clock edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          // out-of-range index first, it must leave every register alone
          write_reg(REG_UNUSED, 32'hFFFF_FFFF);
          write_all_regs(0, 160, 200, 20, 5, 32'd300000, 10);
        end
        1: write_all_regs(0, 160, 200, 20, 5, 32'd300000, 10);
        2: write_all_regs(1, 160, 200, 20, 5, 32'd60000, 10);
        // top of range for temperatures and margins, zero interval and threshold
        3: write_all_regs(1, 32767, 32767, 32767, 32767, 32'd0, 0);
        // setpoint at the bottom disables room demand, no timed resend
        4: write_all_regs(0, -32768, -32768, 0, 0, 32'hFFFF_FFFF, 32767);
        // weather mode with the overheat veto switched off by a zero setpoint
        5: write_all_regs(1, int'($urandom_range(0, 800)) - 400, 0,
                          $urandom_range(0, 60), $urandom_range(0, 40),
                          $urandom_range(0, 100000), $urandom_range(0, 40));
        default: write_all_regs($urandom_range(0, 1), int'($urandom_range(0, 800)) - 400,
                                int'($urandom_range(0, 600)) - 100,
                                $urandom_range(0, 60), $urandom_range(0, 40),
                                $urandom_range(0, 200000), $urandom_range(0, 40));
      endcase
      // last phase runs with both sides at full rate
      calm = (ph == N_PHASES - 1);
      if (ph == 0) begin
        // safety check while off, disabled while off, no demand, sensors bad at start
        pending_events.push_back(heat_event(CMD_SAFETY, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 0, VLD_ALL, 150, 100, 500, 0));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_NONE, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 500, 0));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 250, 100, 500, 0));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 0, VLD_ALL, 150, 100, 500, 0));
        // activation, small change held back, big change resent, timed refresh
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 600, 100));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 605, 1000));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 616, 2000));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 616, 302001));
        // inside the hysteresis band, then the band top reached
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 204, 100, 616, 302002));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 205, 100, 616, 302003));
        // remote on without demand, target swings across the whole range
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_ON, WATER_IDLE,
                                            0, 1, VLD_ALL, 250, 100, 32767, 302004));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, -32768, 302005));
        // both overrides at once: remote off wins
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_BOTH, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, -32768, 302006));
        // water deferral, on demand and on the remote on override
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_WINS,
                                            0, 1, VLD_ALL, 150, 100, 500, 302007));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_ON, WATER_WINS,
                                            0, 1, VLD_ALL, 250, 100, 500, 302008));
        // autotune with no valid readings, time at the wrap point
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            1, 1, VLD_NONE, 32767, 32767, -32768,
                                            32'hFFFF_FFFF));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            1, 1, VLD_NONE, 32767, -32768, 32767, 0));
        // water priority while on
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_WINS,
                                            0, 1, VLD_ALL, 150, 100, 32767, 1));
        // coldest room, then sensors drop out during evaluation
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, -32768, -32768, 0, 2));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 0, VLD_ALL, -32768, -32768, 0, 3));
        // safety check passes, then trips
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 450, 4));
        pending_events.push_back(heat_event(CMD_SAFETY, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 450, 5));
        pending_events.push_back(heat_event(CMD_SAFETY, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 0, VLD_ALL, 150, 100, 450, 6));
        // heating disabled, then boiler disabled, each while on
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 450, 7));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_BOILER, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 450, 8));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 450, 9));
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_HEAT, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_ALL, 150, 100, 450, 10));
        // room reading invalid: no demand in room mode
        pending_events.push_back(heat_event(CMD_EVALUATE, EN_ALL, OVR_NONE, WATER_IDLE,
                                            0, 1, VLD_OUTSIDE, 150, 100, 450, 11));
      end else begin
        repeat (RAND_PER_PHASE) pending_events.push_back(random_event());
      end
      // sender holds off until every owed result is back
      wait_for_idle();
    end

    $display("%0d events over %0d register settings, %0d register writes",
             events_sent, N_PHASES, cfg_writes);
    $display("%0d results checked: %0d set, %0d clear, %0d deferred",
             results_seen, sets_seen, clears_seen, defers_seen);
    if (fail_count == 0) begin
      $display("tb_heating_demand_sequencer_unit passed");
    end else begin
      $display("tb_heating_demand_sequencer_unit failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/hds_pkg.sv
hw/rtl/hds_in_if.sv
hw/rtl/hds_out_if.sv
hw/rtl/hds_cfg_if.sv
hw/rtl/hds_demand.sv
hw/rtl/heating_demand_sequencer_unit.sv
hw/rtl/hds_checker.sv
tb/tb_heating_demand_sequencer_unit.sv
